[rtl/bbtw_pkg.sv]
package bbtw_pkg;

  localparam int REPLY_BITS = 32;
  localparam int BODY_BYTES = 4;

  localparam int BC_W = $clog2(REPLY_BITS + 1);
  localparam int FP_W = $clog2(BODY_BYTES + 3);

  localparam logic [7:0] HDR_FIRST  = 8'h7A;
  localparam logic [7:0] HDR_SECOND = 8'h62;
  localparam logic [7:0] SLEEP_CMD  = 8'h02;

  localparam logic [1:0] GLITCH_MAX = 2'd3;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 32;

  // result word, lowest field last in the packed order
  typedef struct packed {
    logic [15:0] sleep_time;
    logic        sleep_request;
    logic [7:0]  command_code;
    logic        frame_done;
    logic        sda_enable;
    logic        sda_level;
  } result_t;

endpackage

[rtl/bitbang_two_wire_frame_slave.sv]
// two-wire frame slave, fed one sampled sda/scl pair per input word
//
// in_tdata carries the pin sample and the two reply halves; every accepted
// input word produces exactly one result word on the out_ channel
// (sda drive level and enable, frame completion flag and decoded frame).
// scl rising edges shift sda into bytes lsb first; bytes are matched
// against the header 0x7a 0x62 followed by the body bytes; a completed
// frame starts a reply of REPLY_BITS bits, one per scl rise, lsb first.
//
// throughput: one word per cycle while the receiver takes results;
// the whole update is one pass of logic from the state registers to
// the state and output registers, and the result word is registered.
// in_tready is high whenever the output register is empty or being taken,
// so a stalled receiver holds the result and blocks only new input.
// reset (rst_n low, synchronous) clears the pin history, bit assembly,
// parser position and reply state and empties the output register;
// the body byte store is not cleared and is always written before read.
module bitbang_two_wire_frame_slave (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // sda, scl, reply_first[15:0], reply_second[15:0], zero pad
  input  logic [bbtw_pkg::IN_DATA_W-1:0]      in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // sda_level, sda_enable, frame_done, command_code[7:0], sleep_request,
  // sleep_time[15:0], zero pad
  output logic [bbtw_pkg::OUT_DATA_W-1:0]     out_tdata
);
  import bbtw_pkg::*;

  logic            sda;
  logic            scl;
  logic [15:0]     reply_first;
  logic [15:0]     reply_second;

  logic [1:0]      prev_pins_r, prev_pins_nxt;
  logic [1:0]      glitch_r, glitch_nxt;
  logic [BC_W-1:0] bit_count_r, bit_count_nxt;
  logic [7:0]      shift_byte_r, shift_byte_nxt;
  logic [FP_W-1:0] frame_pos_r, frame_pos_nxt;
  logic [7:0]      body_r [BODY_BYTES];
  logic [7:0]      body_nxt [BODY_BYTES];
  logic            sending_r, sending_nxt;
  logic            drive_r, drive_nxt;
  logic            out_valid_r;
  result_t         result_r, result_nxt;

  logic [1:0]      pins;
  logic [1:0]      diff;
  logic            clk_changed;
  logic            rise;
  logic            done;
  logic            accept;
  logic [7:0]      sb_bit;
  logic [BC_W-1:0] bc_inc;
  logic [FP_W-1:0] fp_inc;
  logic [15:0]     word;
  logic [7:0]      cmd;
  logic [7:0]      body_one;
  logic [7:0]      body_two;

  assign sda          = in_tdata[0];
  assign scl          = in_tdata[1];
  assign reply_first  = in_tdata[17:2];
  assign reply_second = in_tdata[33:18];

  assign in_tready  = !out_valid_r || out_tready;
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - $bits(result_t)){1'b0}}, result_r};

  assign pins        = {scl, sda};
  assign diff        = pins ^ prev_pins_r;
  assign clk_changed = diff[1];
  assign rise        = clk_changed && scl;
  assign bc_inc      = bit_count_r + BC_W'(1);
  assign fp_inc      = frame_pos_r + FP_W'(1);
  assign word        = (32'(bit_count_r) >= 32'd16) ? reply_second : reply_first;

  always_comb begin
    prev_pins_nxt  = pins;
    glitch_nxt     = glitch_r;
    bit_count_nxt  = bit_count_r;
    shift_byte_nxt = shift_byte_r;
    frame_pos_nxt  = frame_pos_r;
    sending_nxt    = sending_r;
    drive_nxt      = drive_r;
    done           = 1'b0;
    sb_bit         = shift_byte_r | (8'(sda) << bit_count_r[2:0]);
    for (int i = 0; i < BODY_BYTES; i++) begin
      body_nxt[i] = body_r[i];
    end

    if (diff[0] && glitch_r != GLITCH_MAX) begin
      glitch_nxt = glitch_r + 2'd1;
    end
    if (clk_changed) begin
      glitch_nxt = '0;
    end

    if (!sending_r) begin
      if (glitch_nxt == GLITCH_MAX) begin
        glitch_nxt     = '0;
        bit_count_nxt  = '0;
        shift_byte_nxt = '0;
      end else if (rise) begin
        shift_byte_nxt = sb_bit;
        bit_count_nxt  = bc_inc;
        if (32'(bc_inc) >= 32'd8) begin
          bit_count_nxt  = '0;
          shift_byte_nxt = '0;
          // frame parser
          if (32'(frame_pos_r) >= 32'd2) begin
            for (int i = 0; i < BODY_BYTES; i++) begin
              if (32'(frame_pos_r) == i + 2) begin
                body_nxt[i] = sb_bit;
              end
            end
            frame_pos_nxt = fp_inc;
            if (32'(fp_inc) >= BODY_BYTES + 2) begin
              frame_pos_nxt = '0;
              done          = 1'b1;
            end
          end
          if (sb_bit == HDR_SECOND) begin
            frame_pos_nxt = (frame_pos_nxt == FP_W'(1)) ? FP_W'(2) : '0;
          end
          if (sb_bit == HDR_FIRST && frame_pos_nxt == '0) begin
            frame_pos_nxt = FP_W'(1);
          end
          if (done) begin
            drive_nxt   = 1'b0;
            sending_nxt = 1'b1;
          end
        end
      end
    end else if (rise) begin
      drive_nxt     = word[bit_count_r[3:0]];
      bit_count_nxt = bc_inc;
      if (32'(bc_inc) >= REPLY_BITS) begin
        sending_nxt   = 1'b0;
        bit_count_nxt = '0;
      end
    end
  end

  assign cmd      = body_nxt[0];
  assign body_one = (BODY_BYTES > 1) ? body_nxt[1] : '0;
  assign body_two = (BODY_BYTES > 2) ? body_nxt[2] : '0;

  always_comb begin
    result_nxt.sda_level     = drive_nxt;
    result_nxt.sda_enable    = sending_nxt;
    result_nxt.frame_done    = done;
    result_nxt.command_code  = done ? cmd : '0;
    result_nxt.sleep_request = done && (cmd == SLEEP_CMD);
    result_nxt.sleep_time    = done ? {body_two, body_one} : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_pins_r  <= '0;
      glitch_r     <= '0;
      bit_count_r  <= '0;
      shift_byte_r <= '0;
      frame_pos_r  <= '0;
      sending_r    <= 1'b0;
      drive_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (accept) begin
        prev_pins_r  <= prev_pins_nxt;
        glitch_r     <= glitch_nxt;
        bit_count_r  <= bit_count_nxt;
        shift_byte_r <= shift_byte_nxt;
        frame_pos_r  <= frame_pos_nxt;
        sending_r    <= sending_nxt;
        drive_r      <= drive_nxt;
        out_valid_r  <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result_r <= result_nxt;
      for (int i = 0; i < BODY_BYTES; i++) begin
        body_r[i] <= body_nxt[i];
      end
    end
  end

  a_idle_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[2] |-> out_tdata[27:3] == '0)
    else $error("frame fields set without frame completion");

  a_done_drives: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2] |-> out_tdata[1] && !out_tdata[0])
    else $error("completed frame did not start driving sda low");

  a_tx_count: assert property (@(posedge clk) disable iff (!rst_n)
    sending_r |-> 32'(bit_count_r) < REPLY_BITS)
    else $error("reply bit index out of range");

  a_rx_count: assert property (@(posedge clk) disable iff (!rst_n)
    !sending_r |-> 32'(bit_count_r) < 32'd8)
    else $error("receive bit index out of range");

endmodule
